// ===== design/tlr_pkg.sv =====
// Shared constants and types for the thick line rasterizer.
// No dependencies; imported by tlr_setup and thick_line_rasterizer.
package tlr_pkg;

  // Field and register widths fixed by the interface
  localparam int OUT_W   = 12;
  localparam int THICK_W = 4;
  localparam int ORG_W   = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_THICKNESS = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X  = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd2;

  // Register reset values
  localparam logic [THICK_W-1:0] THICKNESS_RST = 4'd1;
  localparam logic [ORG_W-1:0]   ORIGIN_X_RST  = 10'd300;
  localparam logic [ORG_W-1:0]   ORIGIN_Y_RST  = 10'd250;

  // Input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Direction of travel, decided once per line
  typedef struct packed {
    logic step_x_neg;
    logic step_y_neg;
    logic steep;
  } octant_t;

endpackage

// ===== design/tlr_setup.sv =====
// Line setup: endpoint deltas, octant and Bresenham error terms.
// Depends on tlr_pkg (octant_t).
module tlr_setup import tlr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output octant_t                      octant,
  output logic        [COORD_BITS:0]   major_len,
  output logic signed [COORD_BITS+3:0] dec_init,
  output logic signed [COORD_BITS+3:0] inc_axis,
  output logic signed [COORD_BITS+3:0] inc_diag
);

  localparam int LW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 4;

  logic signed [LW-1:0] dx;
  logic signed [LW-1:0] dy;
  logic        [LW-1:0] adx;
  logic        [LW-1:0] ady;
  logic        [LW-1:0] minor_len;
  logic signed [DW-1:0] major_ext;
  logic signed [DW-1:0] minor_ext;

  // Signed deltas and their magnitudes
  assign dx  = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
  assign dy  = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
  assign adx = dx[LW-1] ? LW'(-dx) : LW'(dx);
  assign ady = dy[LW-1] ? LW'(-dy) : LW'(dy);

  // Major axis is the longer one; x wins a tie
  assign octant.step_x_neg = dx[LW-1];
  assign octant.step_y_neg = dy[LW-1];
  assign octant.steep      = ady > adx;
  assign major_len         = octant.steep ? ady : adx;
  assign minor_len         = octant.steep ? adx : ady;

  // Error terms: start value and the two increments
  assign major_ext = $signed({{(DW-LW){1'b0}}, major_len});
  assign minor_ext = $signed({{(DW-LW){1'b0}}, minor_len});
  assign inc_axis  = minor_ext <<< 1;
  assign inc_diag  = (minor_ext - major_ext) <<< 1;
  assign dec_init  = (minor_ext <<< 1) - major_ext;

endmodule

// ===== design/thick_line_rasterizer.sv =====
// Thick line rasterizer top level: Bresenham stepper with APB register port.
// Depends on tlr_pkg and tlr_setup.
//
// Input channel (in_valid / in_stall): a load transfer (in_cmd = load)
// latches two signed endpoints and gives no result. Each step transfer
// gives one result: the next screen pixel (x + origin_x, origin_y - y),
// with pass_last on the final pixel of a pass and line_last on the final
// pixel of the last pass. A step once the line is finished, or before any
// load, gives a result with every field zero. The thickness register sets
// the number of passes, each one column to the right of the previous one.
// The result appears on out_valid in the cycle after its input transfer.
// Throughput: one item per cycle while in_stall is low; the step add on
// the error term and the coordinate update are combinational, ahead of
// the line state registers.
// A stalled result holds in the output register; the input side stalls
// only while that register is full and out_stall is high.
// Reset (rst_n low, synchronous) leaves the block idle with registers at
// thickness 1, origin_x 300, origin_y 250.
module thick_line_rasterizer import tlr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     out_pixel_x,
  output logic signed [OUT_W-1:0]     out_pixel_y,
  output logic                        out_pixel_valid,
  output logic                        out_pass_last,
  output logic                        out_line_last,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic        [ADDR_W-1:0]    paddr,
  input  logic        [DATA_W-1:0]    pwdata,
  output logic        [DATA_W-1:0]    prdata,
  output logic                        pready
);

  localparam int LW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 4;
  localparam int CW = COORD_BITS + 2;
  localparam int SW = ((CW > OUT_W) ? CW : OUT_W) + 1;

  // Configuration registers
  logic [THICK_W-1:0] thickness_r;
  logic [ORG_W-1:0]   origin_x_r;
  logic [ORG_W-1:0]   origin_y_r;
  logic               cfg_wr;

  // Line state
  logic                 busy_r, busy_nxt;
  octant_t              octant_r, octant_nxt;
  logic        [LW-1:0] major_len_r, major_len_nxt;
  logic        [LW-1:0] steps_done_r, steps_done_nxt;
  logic [THICK_W-1:0]   pass_index_r, pass_index_nxt;
  logic signed [DW-1:0] decision_r, decision_nxt;
  logic signed [DW-1:0] dec_init_r, dec_init_nxt;
  logic signed [DW-1:0] inc_axis_r, inc_axis_nxt;
  logic signed [DW-1:0] inc_diag_r, inc_diag_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt;
  logic signed [CW-1:0] cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] saved_x_r, saved_x_nxt;
  logic signed [COORD_BITS-1:0] saved_y_r, saved_y_nxt;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] pixel_x_r, pixel_x_nxt;
  logic signed [OUT_W-1:0] pixel_y_r, pixel_y_nxt;
  logic                    pixel_valid_r, pixel_valid_nxt;
  logic                    pass_last_r, pass_last_nxt;
  logic                    line_last_r, line_last_nxt;

  // Setup outputs
  octant_t              su_octant;
  logic        [LW-1:0] su_major_len;
  logic signed [DW-1:0] su_dec_init;
  logic signed [DW-1:0] su_inc_axis;
  logic signed [DW-1:0] su_inc_diag;

  // Datapath helpers
  logic                     acc, acc_load, acc_step;
  logic [THICK_W-1:0]       passes;
  logic                     plast, llast;
  logic [THICK_W-1:0]       pass_inc;
  logic signed [COORD_BITS-1:0] base_x;
  logic [THICK_W-1:0]       base_shift;
  logic signed [CW-1:0]     start_x;
  logic signed [CW-1:0]     step_x, step_y;
  logic signed [SW-1:0]     scr_x, scr_y;

  // ---------------------------------------------------------------
  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thickness_r <= THICKNESS_RST;
      origin_x_r  <= ORIGIN_X_RST;
      origin_y_r  <= ORIGIN_Y_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THICKNESS: thickness_r <= pwdata[THICK_W-1:0];
        REG_ORIGIN_X:  origin_x_r  <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:  origin_y_r  <= pwdata[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THICKNESS: prdata = {{(DATA_W-THICK_W){1'b0}}, thickness_r};
      REG_ORIGIN_X:  prdata = {{(DATA_W-ORG_W){1'b0}}, origin_x_r};
      REG_ORIGIN_Y:  prdata = {{(DATA_W-ORG_W){1'b0}}, origin_y_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Handshake: stall only when the result register is full and held
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign acc_load = acc && (in_cmd == CMD_LOAD);
  assign acc_step = acc && (in_cmd == CMD_STEP);

  tlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x_start   (in_x_start),
    .y_start   (in_y_start),
    .x_end     (in_x_end),
    .y_end     (in_y_end),
    .octant    (su_octant),
    .major_len (su_major_len),
    .dec_init  (su_dec_init),
    .inc_axis  (su_inc_axis),
    .inc_diag  (su_inc_diag)
  );

  // End of pass / end of line; thickness zero counts as one pass
  assign passes   = (thickness_r == '0) ? THICK_W'(1) : thickness_r;
  assign plast    = steps_done_r >= major_len_r;
  assign llast    = plast && ({1'b0, pass_index_r} + 5'd1 >= {1'b0, passes});
  assign pass_inc = pass_index_r + THICK_W'(1);

  // Start column of a pass: saved x shifted right by the pass index
  assign base_x     = acc_load ? in_x_start : saved_x_r;
  assign base_shift = acc_load ? '0 : pass_inc;
  assign start_x    = $signed({{(CW-COORD_BITS){base_x[COORD_BITS-1]}}, base_x})
                    + $signed({{(CW-THICK_W){1'b0}}, base_shift});

  // Unit steps: all ones is -1, otherwise +1
  assign step_x = cur_x_r + $signed({{(CW-1){octant_r.step_x_neg}}, 1'b1});
  assign step_y = cur_y_r + $signed({{(CW-1){octant_r.step_y_neg}}, 1'b1});

  // Screen mapping, kept to the low bits of the result
  assign scr_x = $signed({{(SW-CW){cur_x_r[CW-1]}}, cur_x_r})
               + $signed({{(SW-ORG_W){1'b0}}, origin_x_r});
  assign scr_y = $signed({{(SW-ORG_W){1'b0}}, origin_y_r})
               - $signed({{(SW-CW){cur_y_r[CW-1]}}, cur_y_r});

  // ---------------------------------------------------------------
  // Line state update
  always_comb begin
    busy_nxt       = busy_r;
    octant_nxt     = octant_r;
    major_len_nxt  = major_len_r;
    steps_done_nxt = steps_done_r;
    pass_index_nxt = pass_index_r;
    decision_nxt   = decision_r;
    dec_init_nxt   = dec_init_r;
    inc_axis_nxt   = inc_axis_r;
    inc_diag_nxt   = inc_diag_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    saved_x_nxt    = saved_x_r;
    saved_y_nxt    = saved_y_r;
    if (acc_load) begin
      busy_nxt       = 1'b1;
      octant_nxt     = su_octant;
      major_len_nxt  = su_major_len;
      dec_init_nxt   = su_dec_init;
      inc_axis_nxt   = su_inc_axis;
      inc_diag_nxt   = su_inc_diag;
      saved_x_nxt    = in_x_start;
      saved_y_nxt    = in_y_start;
      pass_index_nxt = '0;
      steps_done_nxt = '0;
      decision_nxt   = su_dec_init;
      cur_x_nxt      = start_x;
      cur_y_nxt      = $signed({{(CW-COORD_BITS){in_y_start[COORD_BITS-1]}}, in_y_start});
    end else if (acc_step && busy_r) begin
      if (llast) begin
        busy_nxt = 1'b0;
      end else if (plast) begin
        // next pass, one column further right
        pass_index_nxt = pass_inc;
        steps_done_nxt = '0;
        decision_nxt   = dec_init_r;
        cur_x_nxt      = start_x;
        cur_y_nxt      = $signed({{(CW-COORD_BITS){saved_y_r[COORD_BITS-1]}}, saved_y_r});
      end else begin
        steps_done_nxt = steps_done_r + LW'(1);
        if (decision_r[DW-1]) begin
          // axial step along the major axis only
          decision_nxt = decision_r + inc_axis_r;
          if (octant_r.steep) begin
            cur_y_nxt = step_y;
          end else begin
            cur_x_nxt = step_x;
          end
        end else begin
          // diagonal step
          decision_nxt = decision_r + inc_diag_r;
          cur_x_nxt    = step_x;
          cur_y_nxt    = step_y;
        end
      end
    end
  end

  // Result register contents
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    pixel_x_nxt     = pixel_x_r;
    pixel_y_nxt     = pixel_y_r;
    pixel_valid_nxt = pixel_valid_r;
    pass_last_nxt   = pass_last_r;
    line_last_nxt   = line_last_r;
    if (acc_step) begin
      out_valid_nxt = 1'b1;
      if (busy_r) begin
        pixel_x_nxt     = scr_x[OUT_W-1:0];
        pixel_y_nxt     = scr_y[OUT_W-1:0];
        pixel_valid_nxt = 1'b1;
        pass_last_nxt   = plast;
        line_last_nxt   = llast;
      end else begin
        pixel_x_nxt     = '0;
        pixel_y_nxt     = '0;
        pixel_valid_nxt = 1'b0;
        pass_last_nxt   = 1'b0;
        line_last_nxt   = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    octant_r      <= octant_nxt;
    major_len_r   <= major_len_nxt;
    steps_done_r  <= steps_done_nxt;
    pass_index_r  <= pass_index_nxt;
    decision_r    <= decision_nxt;
    dec_init_r    <= dec_init_nxt;
    inc_axis_r    <= inc_axis_nxt;
    inc_diag_r    <= inc_diag_nxt;
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    saved_x_r     <= saved_x_nxt;
    saved_y_r     <= saved_y_nxt;
    pixel_x_r     <= pixel_x_nxt;
    pixel_y_r     <= pixel_y_nxt;
    pixel_valid_r <= pixel_valid_nxt;
    pass_last_r   <= pass_last_nxt;
    line_last_r   <= line_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_pixel_valid = pixel_valid_r;
  assign out_pass_last   = pass_last_r;
  assign out_line_last   = line_last_r;

`ifndef SYNTHESIS
  // Idle results carry no end markers
  a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_valid) |-> (!out_pass_last && !out_line_last))
    else $error("idle result with end marker");

  // End of line is always end of a pass
  a_line_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_last) |-> out_pass_last)
    else $error("line_last without pass_last");

  // Last pixel of the line returns the block to idle
  a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_step && busy_r && llast) |=> !busy_r)
    else $error("still busy after last pixel");

  // Step counter never passes the major length
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (steps_done_r <= major_len_r))
    else $error("step count beyond major length");

  // A load starts the first pass from step zero
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load |=> (busy_r && steps_done_r == '0 && pass_index_r == '0))
    else $error("load did not restart the line");
`endif

endmodule

// ===== tb/thick_line_rasterizer_test.sv =====
// Self-checking testbench for thick_line_rasterizer: load and step transfers with random
// idling and backpressure; every pixel is predicted by a local Bresenham stepper.
// Depends on tlr_pkg and the thick_line_rasterizer RTL.
module thick_line_rasterizer_test import tlr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W     = 10;
  localparam int COORD_MIN   = -512;
  localparam int COORD_MAX   = 511;
  localparam int SETTLE      = 6;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             valid;
    logic             pass_last;
    logic             line_last;
  } pixel_t;

  // Block ports
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_cmd = CMD_LOAD;
  logic signed [COORD_W-1:0]  in_x_start = '0;
  logic signed [COORD_W-1:0]  in_y_start = '0;
  logic signed [COORD_W-1:0]  in_x_end = '0;
  logic signed [COORD_W-1:0]  in_y_end = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [OUT_W-1:0]    out_pixel_x;
  logic signed [OUT_W-1:0]    out_pixel_y;
  logic                       out_pixel_valid;
  logic                       out_pass_last;
  logic                       out_line_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Local copy of the registers
  logic [THICK_W-1:0] set_thickness = THICKNESS_RST;
  logic [ORG_W-1:0]   set_origin_x = ORIGIN_X_RST;
  logic [ORG_W-1:0]   set_origin_y = ORIGIN_Y_RST;

  // Local line stepper state
  int ln_x, ln_y, ln_err, ln_major, ln_minor, ln_steps, ln_pass, ln_x0, ln_y0;
  bit ln_x_neg, ln_y_neg, ln_steep, ln_busy;

  pixel_t pending_pixels[$];
  int     fail_count = 0;
  int     items_sent = 0;
  int     quiet_cycles = 0;
  int     hold_left = 0;
  int     rx_gap = 0;
  bit     tx_idle = 1'b1;
  bit     rx_idle = 1'b1;

  thick_line_rasterizer #(.COORD_BITS(COORD_W)) u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void restart_pass();
    ln_x     = ln_x0 + ln_pass;
    ln_y     = ln_y0;
    ln_err   = 2 * ln_minor - ln_major;
    ln_steps = 0;
  endfunction

  // Advance the stepper by one transfer; returns 1 when a pixel result is due
  function automatic bit trace_pixel(input logic cmd, input int xs, ys, xe, ye,
                                     output pixel_t px);
    int dx, dy, passes, sx, sy;
    bit plast, llast;
    px = '0;
    if (cmd == CMD_LOAD) begin
      dx = xe - xs;
      dy = ye - ys;
      ln_x_neg = dx < 0;
      ln_y_neg = dy < 0;
      dx = abs_int(dx);
      dy = abs_int(dy);
      ln_steep = dy > dx;           // tie keeps x as major axis
      ln_major = ln_steep ? dy : dx;
      ln_minor = ln_steep ? dx : dy;
      ln_x0    = xs;
      ln_y0    = ys;
      ln_pass  = 0;
      ln_busy  = 1'b1;
      restart_pass();
      return 1'b0;
    end
    // step after the end or before any load: all-zero result
    if (!ln_busy) return 1'b1;

    passes = (set_thickness == 0) ? 1 : int'(set_thickness);
    plast  = ln_steps >= ln_major;
    llast  = plast && (ln_pass + 1 >= passes);
    px.x         = OUT_W'(ln_x + int'(set_origin_x));
    px.y         = OUT_W'(int'(set_origin_y) - ln_y);
    px.valid     = 1'b1;
    px.pass_last = plast;
    px.line_last = llast;

    if (llast) begin
      ln_busy = 1'b0;
    end else if (plast) begin
      ln_pass++;
      restart_pass();
    end else begin
      sx = ln_x_neg ? -1 : 1;
      sy = ln_y_neg ? -1 : 1;
      if (ln_err < 0) begin
        if (ln_steep) ln_y += sy;
        else ln_x += sx;
        ln_err += 2 * ln_minor;
      end else begin
        ln_x += sx;
        ln_y += sy;
        ln_err += 2 * ln_minor - 2 * ln_major;
      end
      ln_steps++;
    end
    return 1'b1;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- checking

  // Predict on each input transfer, then check each output transfer in order
  always @(posedge clk) begin : pixel_checker
    pixel_t want, got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (trace_pixel(in_cmd, int'(in_x_start), int'(in_y_start), int'(in_x_end),
                        int'(in_y_end), want))
          pending_pixels.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_pixel_x, out_pixel_y, out_pixel_valid, out_pass_last, out_line_last};
        if (pending_pixels.size() == 0) begin
          report_failure($sformatf("unexpected pixel x=%0d y=%0d v=%0b pl=%0b ll=%0b",
                                   $signed(got.x), $signed(got.y), got.valid,
                                   got.pass_last, got.line_last));
        end else begin
          want = pending_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.valid !== want.valid ||
              got.pass_last !== want.pass_last || got.line_last !== want.line_last)
            report_failure({
              $sformatf("pixel mismatch: exp x=%0d y=%0d v=%0b pl=%0b ll=%0b",
                        $signed(want.x), $signed(want.y), want.valid, want.pass_last,
                        want.line_last),
              $sformatf(", got x=%0d y=%0d v=%0b pl=%0b ll=%0b",
                        $signed(got.x), $signed(got.y), got.valid, got.pass_last,
                        got.line_last)});
        end
      end
    end
  end

  // Result side: random hold-off after each transfer, plus long holds on request
  always @(posedge clk) begin : result_receiver
    if (out_valid && !out_stall) rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Give up when nothing moves on either channel for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("thick_line_rasterizer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int rand_coord();
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  // One input transfer; valid stays high afterwards unless a gap follows
  task automatic send_item(input logic cmd, input int xs, ys, xe, ye);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_x_start <= COORD_W'(xs);
    in_y_start <= COORD_W'(ys);
    in_x_end   <= COORD_W'(xe);
    in_y_end   <= COORD_W'(ye);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Step payload is ignored by the block, so it carries random bits
  task automatic step_pixel();
    send_item(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Stop sending and wait until every expected pixel is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [1:0] idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== value)
      report_failure($sformatf("register %0d readback: exp %0d, got %0d", idx, value, rd));
  endtask

  // Registers change only after every expected pixel is back
  task automatic program_regs(input int thick, input int org_x, input int org_y);
    logic [DATA_W-1:0] rd;
    wait_drained();
    apb_access(1'b1, REG_THICKNESS, thick, rd);
    apb_access(1'b1, REG_ORIGIN_X, org_x, rd);
    apb_access(1'b1, REG_ORIGIN_Y, org_y, rd);
    set_thickness = THICK_W'(thick);
    set_origin_x  = ORG_W'(org_x);
    set_origin_y  = ORG_W'(org_y);
    check_readback(REG_THICKNESS, DATA_W'(set_thickness));
    check_readback(REG_ORIGIN_X, DATA_W'(set_origin_x));
    check_readback(REG_ORIGIN_Y, DATA_W'(set_origin_y));
  endtask

  // Mostly complete lines with short random extents; some dropped early, some noise
  task automatic random_lines(input int n_items, input int ext, input int long_ext,
                              input bit allow_idle);
    int first, xs, ys, xe, ye, dx, dy, span, passes, steps, kind;
    first = items_sent;
    while (items_sent - first < n_items) begin
      tx_idle = allow_idle && ($urandom_range(0, 7) != 0);
      rx_idle = allow_idle && ($urandom_range(0, 7) != 0);
      span = ($urandom_range(0, 9) == 0) ? long_ext : ext;
      dx = int'($urandom_range(0, 2 * span)) - span;
      dy = int'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(0, 7))
        0: dy = 0;
        1: dx = 0;
        2: dy = $urandom_range(0, 1) ? dx : -dx;
        default: ;
      endcase
      xs = rand_coord();
      ys = rand_coord();
      xe = xs + dx;
      if (xe > COORD_MAX || xe < COORD_MIN) xe = xs - dx;
      ye = ys + dy;
      if (ye > COORD_MAX || ye < COORD_MIN) ye = ys - dy;
      passes = (set_thickness == 0) ? 1 : int'(set_thickness);
      steps = passes * ((abs_int(dx) > abs_int(dy) ? abs_int(dx) : abs_int(dy)) + 1);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // arbitrary endpoints, a few pixels, then replaced by the next load
        send_item(CMD_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        repeat ($urandom_range(0, 3)) step_pixel();
      end else if (kind <= 2) begin
        // line abandoned part way
        send_item(CMD_LOAD, xs, ys, xe, ye);
        repeat ($urandom_range(0, steps - 1)) step_pixel();
      end else begin
        send_item(CMD_LOAD, xs, ys, xe, ye);
        repeat (steps) step_pixel();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) step_pixel();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_steps();
    send_item(CMD_STEP, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    send_item(CMD_STEP, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
  endtask

  task automatic test_single_point();
    send_item(CMD_LOAD, 0, 0, 0, 0);
    step_pixel();
    step_pixel();
    send_item(CMD_LOAD, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    step_pixel();
  endtask

  // Full-range lines, each dropped by the next load; last one runs to the end
  task automatic test_long_lines();
    send_item(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    repeat (2) step_pixel();
    send_item(CMD_LOAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    repeat (2) step_pixel();
    send_item(CMD_LOAD, 0, COORD_MAX, -3, COORD_MIN);
    repeat (2) step_pixel();
    send_item(CMD_LOAD, 2, 1, -1, 5);
    repeat (6) step_pixel();
  endtask

  task automatic test_default_regs();
    random_lines(300, 10, 40, 1'b1);
  endtask

  task automatic test_thickest();
    program_regs(15, 0, 0);
    random_lines(400, 3, 12, 1'b1);
  endtask

  task automatic test_zero_thickness();
    program_regs(0, 1023, 1023);
    random_lines(250, 10, 40, 1'b1);
  endtask

  task automatic test_random_regs();
    repeat (4) begin
      program_regs($urandom_range(1, 15), $urandom_range(0, 1023), $urandom_range(0, 1023));
      random_lines(100, 8, 30, 1'b1);
    end
  endtask

  // Receiver holds off while the sender keeps offering; later the sender drains
  task automatic test_backpressure();
    program_regs(2, 512, 100);
    hold_left = HOLD_CYCLES;
    random_lines(75, 6, 20, 1'b1);
    wait_drained();
    random_lines(75, 6, 20, 1'b1);
  endtask

  task automatic test_full_rate();
    program_regs(1, 300, 250);
    random_lines(200, 10, 40, 1'b0);
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_steps();
    test_single_point();
    test_long_lines();
    test_default_regs();
    test_thickest();
    test_zero_thickness();
    test_random_regs();
    test_backpressure();
    test_full_rate();
    wait_drained();
    if (fail_count == 0) begin
      $display("thick_line_rasterizer regression: pass");
    end else begin
      $display("thick_line_rasterizer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tlr_pkg.sv
design/tlr_setup.sv
design/thick_line_rasterizer.sv
tb/thick_line_rasterizer_test.sv
